// ----- hw/rtl/fixed_point_vector_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit assertion macros
// Shared concurrent assertion forms for the vector unit.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_VECTOR_UNIT_DEFINES_SVH
`define FIXED_POINT_VECTOR_UNIT_DEFINES_SVH

// Overlapping implication, disabled while reset is high.
`define FPVU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fixed_point_vector_unit assertion failed");

// Non-overlapping implication, disabled while reset is high.
`define FPVU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fixed_point_vector_unit assertion failed");

`endif

// ----- hw/rtl/fpvu_pkg.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit package
// Types, constants and arithmetic helpers shared by the vector unit.
// ---------------------------------------------------------------------------
package fpvu_pkg;

   localparam int LANES       = 4;
   localparam int DATA_WIDTH  = 32;
   localparam int FIELD_LANES = 4;
   localparam int NUM_LANES   = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
   localparam int PRE_W       = 33;
   localparam int ACC_W       = 64;
   localparam int NUM_REGS    = 4;
   localparam int PADDR_W     = $clog2(4 * NUM_REGS);

   localparam logic [1:0] REG_PRE_SHIFT  = 2'd0;
   localparam logic [1:0] REG_PRE_ROUND  = 2'd1;
   localparam logic [1:0] REG_POST_SHIFT = 2'd2;
   localparam logic [1:0] REG_POST_ROUND = 2'd3;

   typedef enum logic [1:0] {
      CMD_DOT    = 2'd0,
      CMD_SCALE  = 2'd1,
      CMD_MADD   = 2'd2,
      CMD_LENGTH = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [4:0]  pre_shift;
      logic [30:0] pre_round;
      logic [5:0]  post_shift;
      logic [30:0] post_round;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      cmd_type              cmd;
      logic [NUM_LANES-1:0] active;
   } ctl_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } res_type;

   function automatic logic signed [PRE_W-1:0] pre_op(input logic [DATA_WIDTH-1:0] x,
                                                      input cfg_type cfg);
      logic signed [DATA_WIDTH-1:0] xs;
      logic signed [PRE_W-1:0]      sum;
      xs  = x;
      sum = PRE_W'(xs) + PRE_W'(cfg.pre_round);
      return sum >>> cfg.pre_shift;
   endfunction

   function automatic logic [ACC_W-1:0] post_op(input logic [ACC_W-1:0] v,
                                                input cfg_type cfg);
      logic signed [ACC_W-1:0] t;
      t = v + ACC_W'(cfg.post_round);
      return t >>> cfg.post_shift;
   endfunction

   function automatic res_type trunc_op(input logic [ACC_W-1:0] v);
      logic signed [DATA_WIDTH-1:0] t;
      res_type                      res;
      t         = v[DATA_WIDTH-1:0];
      res.value = 32'(t);
      res.ovf   = (ACC_W'(t) != v);
      return res;
   endfunction

endpackage

// ----- hw/rtl/fpvu_csr.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit configuration registers
// Holds the rounding and shift registers behind the APB-style port.
// ---------------------------------------------------------------------------
module fpvu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fpvu_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output fpvu_pkg::cfg_type           cfg
);

   fpvu_pkg::cfg_type cfg_ff;
   logic [1:0]        index;

   assign index  = paddr[3:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_shift  <= 5'd0;
         cfg_ff.pre_round  <= 31'd0;
         cfg_ff.post_shift <= 6'd16;
         cfg_ff.post_round <= 31'd32768;
      end else if (psel && penable && pwrite) begin
         case (index)
            fpvu_pkg::REG_PRE_SHIFT:  cfg_ff.pre_shift  <= pwdata[4:0];
            fpvu_pkg::REG_PRE_ROUND:  cfg_ff.pre_round  <= pwdata[30:0];
            fpvu_pkg::REG_POST_SHIFT: cfg_ff.post_shift <= pwdata[5:0];
            fpvu_pkg::REG_POST_ROUND: cfg_ff.post_round <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         fpvu_pkg::REG_PRE_SHIFT:  prdata = 32'(cfg_ff.pre_shift);
         fpvu_pkg::REG_PRE_ROUND:  prdata = 32'(cfg_ff.pre_round);
         fpvu_pkg::REG_POST_SHIFT: prdata = 32'(cfg_ff.post_shift);
         fpvu_pkg::REG_POST_ROUND: prdata = 32'(cfg_ff.post_round);
         default:                  prdata = 32'd0;
      endcase
   end

endmodule

// ----- hw/rtl/fpvu_lane.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit lane
// Pre-rounds, multiplies, post-rounds and truncates one vector element, adding the a operand for multiply-add.
// ---------------------------------------------------------------------------
module fpvu_lane (
   input  logic                              clock,
   input  fpvu_pkg::cfg_type                 cfg,
   input  logic [fpvu_pkg::DATA_WIDTH-1:0]   a_in,
   input  logic [fpvu_pkg::DATA_WIDTH-1:0]   b_in,
   input  logic signed [fpvu_pkg::PRE_W-1:0] s_pre,
   input  fpvu_pkg::cmd_type                 cmd1,
   input  fpvu_pkg::cmd_type                 cmd3,
   input  logic                              active3,
   output logic [fpvu_pkg::ACC_W-1:0]        prod,
   output logic [31:0]                       r,
   output logic                              ovf
);

   localparam int DW = fpvu_pkg::DATA_WIDTH;
   localparam int PW = fpvu_pkg::PRE_W;
   localparam int AW = fpvu_pkg::ACC_W;

   logic signed [PW-1:0]   pa_ff, pb_ff;
   logic [DW-1:0]          a1_ff, a2_ff, a3_ff;
   logic signed [PW-1:0]   x_op, y_op;
   logic signed [2*PW-1:0] full;
   logic [AW-1:0]          prod_ff, post_ff;
   logic [31:0]            r_ff, r_in;
   logic                   ovf_ff, ovf_in;
   fpvu_pkg::res_type      term, madd;
   logic signed [DW-1:0]   a_s, term_s;
   logic signed [DW:0]     msum;

   always_comb begin
      case (cmd1)
         fpvu_pkg::CMD_DOT: begin
            x_op = pa_ff;
            y_op = pb_ff;
         end
         fpvu_pkg::CMD_SCALE: begin
            x_op = pa_ff;
            y_op = s_pre;
         end
         fpvu_pkg::CMD_MADD: begin
            x_op = pb_ff;
            y_op = s_pre;
         end
         default: begin
            x_op = pa_ff;
            y_op = pa_ff;
         end
      endcase
      full = x_op * y_op;
   end

   always_comb begin
      term   = fpvu_pkg::trunc_op(post_ff);
      a_s    = a3_ff;
      term_s = term.value[DW-1:0];
      msum   = (DW+1)'(a_s) + (DW+1)'(term_s);
      madd   = fpvu_pkg::trunc_op(AW'(msum));
      if (!active3) begin
         r_in   = 32'd0;
         ovf_in = 1'b0;
      end else if (cmd3 == fpvu_pkg::CMD_MADD) begin
         r_in   = madd.value;
         ovf_in = term.ovf | madd.ovf;
      end else begin
         r_in   = term.value;
         ovf_in = term.ovf;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff   <= fpvu_pkg::pre_op(a_in, cfg);
      pb_ff   <= fpvu_pkg::pre_op(b_in, cfg);
      a1_ff   <= a_in;
      a2_ff   <= a1_ff;
      a3_ff   <= a2_ff;
      prod_ff <= full[AW-1:0];
      post_ff <= fpvu_pkg::post_op(prod_ff, cfg);
      r_ff    <= r_in;
      ovf_ff  <= ovf_in;
   end

   assign prod = prod_ff;
   assign r    = r_ff;
   assign ovf  = ovf_ff;

endmodule

// ----- hw/rtl/fpvu_merge.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit merge stage
// Sums lane products for scalar commands and assembles the result transfer.
// ---------------------------------------------------------------------------
module fpvu_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  fpvu_pkg::cfg_type          cfg,
   input  fpvu_pkg::ctl_type          ctl2,
   input  fpvu_pkg::ctl_type          ctl4,
   input  logic [fpvu_pkg::ACC_W-1:0] prod [fpvu_pkg::NUM_LANES],
   input  logic [31:0]                lane_r [fpvu_pkg::NUM_LANES],
   input  logic                       lane_ovf [fpvu_pkg::NUM_LANES],
   output logic                       strobe,
   output logic [31:0]                r [fpvu_pkg::FIELD_LANES],
   output logic                       ovf
);

   localparam int AW = fpvu_pkg::ACC_W;

   logic [AW-1:0]     sum_ff, sum_in, scal_ff;
   logic [31:0]       r_ff [fpvu_pkg::FIELD_LANES];
   logic [31:0]       r_in [fpvu_pkg::FIELD_LANES];
   logic              ovf_ff, ovf_in, strobe_ff;
   fpvu_pkg::res_type scal;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < fpvu_pkg::NUM_LANES; i++) begin
         if (ctl2.active[i]) begin
            sum_in = sum_in + prod[i];
         end
      end
   end

   always_comb begin
      scal = fpvu_pkg::trunc_op(scal_ff);
      for (int i = 0; i < fpvu_pkg::FIELD_LANES; i++) begin
         r_in[i] = 32'd0;
      end
      ovf_in = 1'b0;
      if (ctl4.cmd == fpvu_pkg::CMD_DOT || ctl4.cmd == fpvu_pkg::CMD_LENGTH) begin
         r_in[0] = scal.value;
         ovf_in  = scal.ovf;
      end else begin
         for (int i = 0; i < fpvu_pkg::NUM_LANES; i++) begin
            r_in[i] = lane_r[i];
            ovf_in  = ovf_in | lane_ovf[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      scal_ff <= fpvu_pkg::post_op(sum_ff, cfg);
      r_ff    <= r_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl4.valid;
      end
   end

   assign strobe = strobe_ff;
   assign r      = r_ff;
   assign ovf    = ovf_ff;

endmodule

// ----- hw/rtl/fixed_point_vector_unit.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit
// Dot product, scaling, multiply-add and length squared on up to four lanes.
// ---------------------------------------------------------------------------
// The unit accepts a command in every clock cycle: busy is never raised, and
// each result appears on the result ports for one cycle with rsp_strobe high.
// The receiver cannot stall, so it must take every result in the cycle in
// which it is shown. The five stages are operand pre-rounding, the per-lane
// multiplier, post-rounding of lane products alongside the product sum,
// post-rounding of the sum with the lane truncation and multiply-add, and the
// output register.
`include "fixed_point_vector_unit_defines.svh"

module fixed_point_vector_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [2:0]                   req_count,
   input  logic signed [31:0]           req_a0,
   input  logic signed [31:0]           req_a1,
   input  logic signed [31:0]           req_a2,
   input  logic signed [31:0]           req_a3,
   input  logic signed [31:0]           req_b0,
   input  logic signed [31:0]           req_b1,
   input  logic signed [31:0]           req_b2,
   input  logic signed [31:0]           req_b3,
   input  logic signed [31:0]           req_scale_value,
   output logic                         rsp_strobe,
   output logic signed [31:0]           rsp_r0,
   output logic signed [31:0]           rsp_r1,
   output logic signed [31:0]           rsp_r2,
   output logic signed [31:0]           rsp_r3,
   output logic                         rsp_overflow,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fpvu_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int DW = fpvu_pkg::DATA_WIDTH;
   localparam int NL = fpvu_pkg::NUM_LANES;

   fpvu_pkg::cfg_type          cfg;
   fpvu_pkg::ctl_type          ctl1_in, ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [2:0]                 cnt;
   logic signed [fpvu_pkg::PRE_W-1:0] s_pre_ff;
   logic [31:0]                a_in [fpvu_pkg::FIELD_LANES];
   logic [31:0]                b_in [fpvu_pkg::FIELD_LANES];
   logic [fpvu_pkg::ACC_W-1:0] prod [NL];
   logic [31:0]                lane_r [NL];
   logic                       lane_ovf [NL];
   logic [31:0]                r_out [fpvu_pkg::FIELD_LANES];

   assign busy = 1'b0;

   assign a_in[0] = req_a0;
   assign a_in[1] = req_a1;
   assign a_in[2] = req_a2;
   assign a_in[3] = req_a3;
   assign b_in[0] = req_b0;
   assign b_in[1] = req_b1;
   assign b_in[2] = req_b2;
   assign b_in[3] = req_b3;

   always_comb begin
      if (req_count < 3'd2) begin
         cnt = 3'd2;
      end else if (req_count > 3'(NL)) begin
         cnt = 3'(NL);
      end else begin
         cnt = req_count;
      end
      ctl1_in.valid = start && !busy;
      ctl1_in.cmd   = fpvu_pkg::cmd_type'(req_command);
      for (int i = 0; i < NL; i++) begin
         ctl1_in.active[i] = (3'(i) < cnt);
      end
   end

   always_ff @(posedge clock) begin
      s_pre_ff <= fpvu_pkg::pre_op(req_scale_value[DW-1:0], cfg);
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   fpvu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   for (genvar g = 0; g < NL; g++) begin : g_lane
      fpvu_lane u_lane (
         .clock   (clock),
         .cfg     (cfg),
         .a_in    (a_in[g][DW-1:0]),
         .b_in    (b_in[g][DW-1:0]),
         .s_pre   (s_pre_ff),
         .cmd1    (ctl1_ff.cmd),
         .cmd3    (ctl3_ff.cmd),
         .active3 (ctl3_ff.active[g]),
         .prod    (prod[g]),
         .r       (lane_r[g]),
         .ovf     (lane_ovf[g])
      );
   end

   fpvu_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ctl2     (ctl2_ff),
      .ctl4     (ctl4_ff),
      .prod     (prod),
      .lane_r   (lane_r),
      .lane_ovf (lane_ovf),
      .strobe   (rsp_strobe),
      .r        (r_out),
      .ovf      (rsp_overflow)
   );

   assign rsp_r0 = r_out[0];
   assign rsp_r1 = r_out[1];
   assign rsp_r2 = r_out[2];
   assign rsp_r3 = r_out[3];

   `FPVU_ASSERT_IMPLIES(a_latency, clock, reset, start && !busy, ##5 rsp_strobe)
   `FPVU_ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_strobe, $past(start && !busy, 5))
   `FPVU_ASSERT_NEXT(a_scalar_zero, clock, reset, ctl4_ff.valid && (ctl4_ff.cmd == fpvu_pkg::CMD_DOT || ctl4_ff.cmd == fpvu_pkg::CMD_LENGTH), rsp_r1 == 32'd0 && rsp_r2 == 32'd0 && rsp_r3 == 32'd0)

endmodule

// ----- tb/sv/vector_result_check.sv -----
// ---------------------------------------------------------------------------
// Vector unit result checker
// Follows register writes and command transfers, works out the lanes and the
// overflow flag that each command must give, and compares every result
// transfer with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module vector_result_check
   import fpvu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_count,
   input  logic [31:0]        req_a0,
   input  logic [31:0]        req_a1,
   input  logic [31:0]        req_a2,
   input  logic [31:0]        req_a3,
   input  logic [31:0]        req_b0,
   input  logic [31:0]        req_b1,
   input  logic [31:0]        req_b2,
   input  logic [31:0]        req_b3,
   input  logic [31:0]        req_scale_value,
   input  logic               rsp_strobe,
   input  logic [31:0]        rsp_r0,
   input  logic [31:0]        rsp_r1,
   input  logic [31:0]        rsp_r2,
   input  logic [31:0]        rsp_r3,
   input  logic               rsp_overflow,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output int                 mismatch_count,
   output int                 results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0][31:0] lane;
      logic             ovf;
   } lane_values_t;

   cfg_type      regs;
   lane_values_t lanes_due[$];
   int           errs;
   int           seen;

   function automatic logic [63:0] from_data(input logic [31:0] x);
      logic signed [DATA_WIDTH-1:0] n;
      n = x[DATA_WIDTH-1:0];
      return 64'(n);
   endfunction

   function automatic logic [63:0] shift_down(input logic [63:0] v, input int unsigned amount);
      logic signed [63:0] t;
      t = v;
      return t >>> amount;
   endfunction

   function automatic logic [63:0] pre_scale(input logic [63:0] v, input cfg_type c);
      return shift_down(v + 64'(c.pre_round), c.pre_shift);
   endfunction

   function automatic logic [63:0] post_scale(input logic [63:0] v, input cfg_type c);
      return shift_down(v + 64'(c.post_round), c.post_shift);
   endfunction

   function automatic logic narrows(input logic [63:0] v);
      return from_data(v[31:0]) != v;
   endfunction

   function automatic lane_values_t vector_outcome(input cmd_type op,
                                                   input logic [2:0] count_in,
                                                   input logic [3:0][31:0] a,
                                                   input logic [3:0][31:0] b,
                                                   input logic [31:0] scalar,
                                                   input cfg_type c);
      lane_values_t res;
      int           n;
      logic [63:0]  acc;
      logic [63:0]  x;
      logic [63:0]  y;
      logic [63:0]  s;
      logic [63:0]  term;
      res = '0;
      n = int'(count_in);
      if (n < 2) n = 2;
      if (n > NUM_LANES) n = NUM_LANES;
      s = pre_scale(from_data(scalar), c);
      if (op == CMD_DOT || op == CMD_LENGTH) begin
         acc = '0;
         for (int i = 0; i < n; i++) begin
            x = pre_scale(from_data(a[i]), c);
            y = (op == CMD_DOT) ? pre_scale(from_data(b[i]), c) : x;
            acc = acc + x * y;
         end
         acc = post_scale(acc, c);
         res.ovf = narrows(acc);
         term = from_data(acc[31:0]);
         res.lane[0] = term[31:0];
      end else begin
         for (int i = 0; i < n; i++) begin
            x = pre_scale(from_data((op == CMD_SCALE) ? a[i] : b[i]), c);
            term = post_scale(x * s, c);
            res.ovf |= narrows(term);
            term = from_data(term[31:0]);
            if (op == CMD_MADD) begin
               term = from_data(a[i]) + term;
               res.ovf |= narrows(term);
               term = from_data(term[31:0]);
            end
            res.lane[i] = term[31:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      lane_values_t want;
      lane_values_t got;
      if (reset) begin
         lanes_due.delete();
         regs.pre_shift  = 5'd0;
         regs.pre_round  = 31'd0;
         regs.post_shift = 6'd16;
         regs.post_round = 31'd32768;
         errs = 0;
         seen = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               REG_PRE_SHIFT:  regs.pre_shift  = pwdata[4:0];
               REG_PRE_ROUND:  regs.pre_round  = pwdata[30:0];
               REG_POST_SHIFT: regs.post_shift = pwdata[5:0];
               REG_POST_ROUND: regs.post_round = pwdata[30:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            seen++;
            got.lane = {rsp_r3, rsp_r2, rsp_r1, rsp_r0};
            got.ovf  = rsp_overflow;
            if (lanes_due.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: result transfer with no command outstanding: %h %h %h %h ovf %b",
                           $realtime, rsp_r0, rsp_r1, rsp_r2, rsp_r3, rsp_overflow);
            end else begin
               want = lanes_due.pop_front();
               if (got.lane[0] !== want.lane[0] || got.lane[1] !== want.lane[1] ||
                   got.lane[2] !== want.lane[2] || got.lane[3] !== want.lane[3] ||
                   got.ovf !== want.ovf) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected r0 %h r1 %h r2 %h r3 %h overflow %b",
                              want.lane[0], want.lane[1], want.lane[2], want.lane[3], want.ovf);
                     $display("   actual   r0 %h r1 %h r2 %h r3 %h overflow %b",
                              got.lane[0], got.lane[1], got.lane[2], got.lane[3], got.ovf);
                  end
               end
            end
         end
         if (start && !busy)
            lanes_due.push_back(vector_outcome(cmd_type'(req_command), req_count,
                                               {req_a3, req_a2, req_a1, req_a0},
                                               {req_b3, req_b2, req_b1, req_b0},
                                               req_scale_value, regs));
      end
      mismatch_count <= errs;
      results_seen   <= seen;
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// Fixed-point vector unit testbench
// Drives directed and random vector commands through several register
// settings, with random gaps between command transfers, and reports the
// verdict from the result checker.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fpvu_pkg::*;

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] NEG  = 32'hFFFF_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_command;
   logic [2:0]         req_count;
   logic [31:0]        req_a0, req_a1, req_a2, req_a3;
   logic [31:0]        req_b0, req_b1, req_b2, req_b3;
   logic [31:0]        req_scale_value;
   logic               rsp_strobe;
   logic [31:0]        rsp_r0, rsp_r1, rsp_r2, rsp_r3;
   logic               rsp_overflow;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   int                 mismatch_count;
   int                 results_seen;
   int                 issued;
   logic [3:0][31:0]   a_vec;
   logic [3:0][31:0]   b_vec;

   fixed_point_vector_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_count       (req_count),
      .req_a0          (req_a0),
      .req_a1          (req_a1),
      .req_a2          (req_a2),
      .req_a3          (req_a3),
      .req_b0          (req_b0),
      .req_b1          (req_b1),
      .req_b2          (req_b2),
      .req_b3          (req_b3),
      .req_scale_value (req_scale_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_r0          (rsp_r0),
      .rsp_r1          (rsp_r1),
      .rsp_r2          (rsp_r2),
      .rsp_r3          (rsp_r3),
      .rsp_overflow    (rsp_overflow),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   vector_result_check i_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_count       (req_count),
      .req_a0          (req_a0),
      .req_a1          (req_a1),
      .req_a2          (req_a2),
      .req_a3          (req_a3),
      .req_b0          (req_b0),
      .req_b1          (req_b1),
      .req_b2          (req_b2),
      .req_b3          (req_b3),
      .req_scale_value (req_scale_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_r0          (rsp_r0),
      .rsp_r1          (rsp_r1),
      .rsp_r2          (rsp_r2),
      .rsp_r3          (rsp_r3),
      .rsp_overflow    (rsp_overflow),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .results_seen    (results_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic issue(input cmd_type op, input logic [2:0] cnt,
                        input logic [3:0][31:0] a, input logic [3:0][31:0] b,
                        input logic [31:0] scalar);
      req_command     <= op;
      req_count       <= cnt;
      req_a0          <= a[0];
      req_a1          <= a[1];
      req_a2          <= a[2];
      req_a3          <= a[3];
      req_b0          <= b[0];
      req_b1          <= b[1];
      req_b2          <= b[2];
      req_b3          <= b[3];
      req_scale_value <= scalar;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      issued++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (results_seen != issued) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic bus_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] pick_fixed_value();
      int unsigned w;
      logic [31:0] m;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: begin
            w = $urandom_range(4, 24);
            m = $urandom & ((32'd1 << w) - 32'd1);
            return m - (32'd1 << (w - 1));
         end
         8: begin
            case ($urandom_range(0, 5))
               0: return MAXV;
               1: return MINV;
               2: return 32'hFFFF_FFFF;
               3: return 32'd1;
               4: return ONE;
               default: return NEG;
            endcase
         end
         default: return 32'd0;
      endcase
   endfunction

   initial begin
      bit          idle_on;
      int unsigned ps;
      int unsigned qs;
      issued          = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_command     <= CMD_DOT;
      req_count       <= 3'd2;
      req_a0          <= '0;
      req_a1          <= '0;
      req_a2          <= '0;
      req_a3          <= '0;
      req_b0          <= '0;
      req_b1          <= '0;
      req_b2          <= '0;
      req_b3          <= '0;
      req_scale_value <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_DOT, 3'd2, {32'd0, 32'd0, 32'h0002_0000, ONE},
            {32'd0, 32'd0, 32'h0004_0000, 32'h0003_0000}, 32'd0);
      issue(CMD_DOT, 3'd4, {4{MAXV}}, {4{MAXV}}, ONE);
      issue(CMD_DOT, 3'd0, {MAXV, MAXV, MINV, MINV}, {MINV, MINV, MAXV, MINV}, MINV);
      issue(CMD_DOT, 3'd1, {4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 32'hFFFF_FFFF);
      issue(CMD_DOT, 3'd5, {ONE, NEG, 32'h0000_8000, ONE}, {NEG, NEG, ONE, 32'h0003_0000}, 0);
      issue(CMD_LENGTH, 3'd4, {4{MINV}}, {4{MAXV}}, 32'd0);
      issue(CMD_LENGTH, 3'd7, {ONE, NEG, 32'h0003_0000, 32'h0000_4000}, {4{MINV}}, MAXV);
      issue(CMD_LENGTH, 3'd3, {MAXV, 32'd0, 32'd0, MAXV}, {4{32'd0}}, 32'd0);
      issue(CMD_LENGTH, 3'd6, {4{MAXV}}, {4{MINV}}, 32'd0);
      issue(CMD_SCALE, 3'd1, {MAXV, MINV, 32'h0002_0000, ONE}, {4{MAXV}}, 32'h0002_0000);
      issue(CMD_SCALE, 3'd4, {MAXV, MINV, 32'hFFFF_FFFF, 32'd1}, {4{32'd0}}, MAXV);
      issue(CMD_SCALE, 3'd5, {32'h0001_8000, NEG, MINV, MAXV}, {4{MINV}}, MINV);
      issue(CMD_SCALE, 3'd3, {4{32'd0}}, {4{32'd0}}, 32'd0);
      issue(CMD_SCALE, 3'd0, {MAXV, MAXV, ONE, NEG}, {4{ONE}}, NEG);
      issue(CMD_MADD, 3'd3, {32'd0, MAXV, MAXV, MAXV}, {32'd0, ONE, ONE, ONE}, ONE);
      issue(CMD_MADD, 3'd2, {MAXV, MAXV, MINV, MINV}, {ONE, ONE, NEG, NEG}, ONE);
      issue(CMD_MADD, 3'd7, {4{MINV}}, {4{MINV}}, MINV);
      issue(CMD_MADD, 3'd0, {ONE, NEG, 32'h0000_0100, 32'hFFFF_FF00},
            {32'h0000_8000, ONE, NEG, MAXV}, 32'h0003_0000);
      issue(CMD_MADD, 3'd4, {4{MAXV}}, {4{MAXV}}, MAXV);
      issue(CMD_DOT, 3'd6, {4{32'd0}}, {4{MAXV}}, MAXV);

      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1: begin
                  write_reg(REG_PRE_SHIFT, 32'd31);
                  write_reg(REG_PRE_ROUND, 32'h7FFF_FFFF);
                  write_reg(REG_POST_SHIFT, 32'd63);
                  write_reg(REG_POST_ROUND, 32'h7FFF_FFFF);
               end
               2: begin
                  write_reg(REG_PRE_SHIFT, 32'd0);
                  write_reg(REG_PRE_ROUND, 32'd0);
                  write_reg(REG_POST_SHIFT, 32'd0);
                  write_reg(REG_POST_ROUND, 32'd0);
               end
               3: begin
                  write_reg(REG_PRE_SHIFT, 32'd8);
                  write_reg(REG_PRE_ROUND, 32'd128);
                  write_reg(REG_POST_SHIFT, 32'd24);
                  write_reg(REG_POST_ROUND, 32'd1 << 23);
               end
               4: begin
                  write_reg(REG_PRE_SHIFT, $urandom);
                  write_reg(REG_PRE_ROUND, $urandom);
                  write_reg(REG_POST_SHIFT, $urandom);
                  write_reg(REG_POST_ROUND, $urandom);
               end
               5: begin
                  ps = $urandom_range(1, 12);
                  qs = $urandom_range(1, 31);
                  write_reg(REG_PRE_SHIFT, ps);
                  write_reg(REG_PRE_ROUND, 32'd1 << (ps - 1));
                  write_reg(REG_POST_SHIFT, qs);
                  write_reg(REG_POST_ROUND, 32'd1 << (qs - 1));
               end
               default: begin
                  write_reg(REG_PRE_SHIFT, 32'd0);
                  write_reg(REG_PRE_ROUND, 32'd0);
                  write_reg(REG_POST_SHIFT, 32'd16);
                  write_reg(REG_POST_ROUND, 32'd32768);
               end
            endcase
            bus_idle();
         end
         for (int k = 0; k < 170; k++) begin
            if (k % 32 == 0)
               idle_on = (phase != 6) && ($urandom_range(0, 2) != 0);
            if (idle_on && $urandom_range(0, 3) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 19)) @(posedge clock);
            end
            for (int i = 0; i < 4; i++) begin
               a_vec[i] = pick_fixed_value();
               b_vec[i] = pick_fixed_value();
            end
            issue(cmd_type'($urandom_range(0, 3)),
                  ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(2, 4)),
                  a_vec, b_vec, pick_fixed_value());
         end
      end

      start <= 1'b0;
      for (int guard = 0; guard < 1000 && results_seen != issued; guard++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_seen == issued)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
